>>> sv/etscan_pkg.sv
// Shared types, constants and character-class functions for the expression token scanner.
package etscan_pkg;

  localparam int MaxStrLen  = 4096;
  localparam int PosW       = $clog2(MaxStrLen);
  localparam int LenW       = $clog2(MaxStrLen + 1);
  localparam int CharW      = 8;
  localparam int ValW       = 31;
  localparam int ProdW      = ValW + 4;
  localparam int KwLen      = 5;
  localparam int KwPosW     = 3;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [ValW-1:0]  ValMax    = {ValW{1'b1}};
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharNul   = 8'h00;

  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_NUM    = 4'd1,
    KIND_ID     = 4'd2,
    KIND_PRINT  = 4'd3,
    KIND_PLUS   = 4'd4,
    KIND_MINUS  = 4'd5,
    KIND_MUL    = 4'd6,
    KIND_DIV    = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_SEMI   = 4'd10,
    KIND_ASSIGN = 4'd11,
    KIND_ERROR  = 4'd12
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [PosW-1:0]  start;
    logic [LenW-1:0]  len;
    logic [ValW-1:0]  value;
    logic             overflow;
    logic [CharW-1:0] err_char;
    logic             last;
  } token_t;

  // Up to two tokens produced by one character, in output order.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_symbol(input logic [CharW-1:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
           (c == 8'h28) || (c == 8'h29) || (c == 8'h3B) || (c == 8'h3D);
  endfunction

  function automatic kind_t symbol_kind(input logic [CharW-1:0] c);
    kind_t k;
    case (c)
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_MUL;
      8'h2F: k = KIND_DIV;
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h3B: k = KIND_SEMI;
      8'h3D: k = KIND_ASSIGN;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Letters of the keyword "print".
  function automatic logic [CharW-1:0] keyword_char(input logic [KwPosW-1:0] idx);
    logic [CharW-1:0] ch;
    case (idx)
      3'd0: ch = 8'h70;
      3'd1: ch = 8'h72;
      3'd2: ch = 8'h69;
      3'd3: ch = 8'h6E;
      3'd4: ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/expression_token_scanner_top.sv
// Flow: a character is held in the input register, and its tokens are then written
// into the result queue, which offers them; the write waits for queue room.
// Throughput: one character per cycle; tokens leave at one per cycle, so characters
// that close a pending token and produce another push two tokens each, and input
// stalls while the four-entry result queue has fewer than two free entries.
// Reset (synchronous, active high) returns the scanner to idle at position zero
// and empties the result queue.
module expression_token_scanner_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_ready,
  input  logic [etscan_pkg::CharW-1:0] char_code,
  output logic                         token_valid,
  input  logic                         token_ready,
  output logic [3:0]                   token_kind,
  output logic [etscan_pkg::PosW-1:0]  start_pos,
  output logic [etscan_pkg::LenW-1:0]  token_length,
  output logic [etscan_pkg::ValW-1:0]  number_value,
  output logic                         value_overflow,
  output logic [etscan_pkg::CharW-1:0] error_char,
  output logic                         last_of_run
);
  import etscan_pkg::*;

  push_t  push;
  logic   room;
  token_t head;

  etscan_core u_core (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .room       (room),
    .push       (push)
  );

  etscan_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head       (head),
    .head_valid (token_valid),
    .head_ready (token_ready)
  );

  assign token_kind     = head.kind;
  assign start_pos      = head.start;
  assign token_length   = head.len;
  assign number_value   = head.value;
  assign value_overflow = head.overflow;
  assign error_char     = head.err_char;
  assign last_of_run    = head.last;

endmodule

>>> sv/etscan_core.sv
// Input register and scanner state: classifies one character and forms up to two tokens.
module etscan_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_ready,
  input  logic [etscan_pkg::CharW-1:0] char_code,
  input  logic                         room,
  output etscan_pkg::push_t            push
);
  import etscan_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_NAME
  } mode_t;

  logic              char_full;
  logic [CharW-1:0]  char_q;
  mode_t             mode,        mode_next;
  logic [PosW-1:0]   token_start, token_start_next;
  logic [PosW-1:0]   position,    position_next;
  logic [LenW-1:0]   run_length,  run_length_next;
  logic [ValW-1:0]   acc,         acc_next;
  logic              ovf,         ovf_next;
  logic [KwPosW-1:0] kw_prog,     kw_prog_next;
  logic              kw_match,    kw_match_next;

  logic              advance;
  logic              dig, let_c;
  logic              cont;
  logic              close_en, new_en;
  token_t            close_tok, new_tok;
  logic [ProdW-1:0]  prod;
  logic [PosW-1:0]   pos_inc;
  logic [LenW-1:0]   len_grow;

  assign advance    = char_full && room;
  assign char_ready = !char_full || advance;

  assign dig      = is_digit(char_q);
  assign let_c    = is_letter(char_q);
  assign prod     = ({{(ProdW-ValW){1'b0}}, acc} << 3) + ({{(ProdW-ValW){1'b0}}, acc} << 1)
                    + {{(ProdW-4){1'b0}}, char_q[3:0]};
  assign pos_inc  = (position == PosW'(MaxStrLen - 1)) ? '0 : position + 1'b1;
  assign len_grow = (run_length < LenW'(MaxStrLen)) ? run_length + 1'b1 : run_length;

  always_comb begin
    mode_next        = mode;
    token_start_next = token_start;
    position_next    = position;
    run_length_next  = run_length;
    acc_next         = acc;
    ovf_next         = ovf;
    kw_prog_next     = kw_prog;
    kw_match_next    = kw_match;
    cont             = 1'b1;
    close_en         = 1'b0;
    new_en           = 1'b0;
    close_tok        = '0;
    new_tok          = '0;
    push             = '0;

    if (advance) begin
      case (mode)
        MODE_NUM: begin
          if (dig) begin
            if (ovf || (|prod[ProdW-1:ValW])) begin
              acc_next = ValMax;
              ovf_next = 1'b1;
            end else begin
              acc_next = prod[ValW-1:0];
            end
            run_length_next = len_grow;
            position_next   = pos_inc;
            cont            = 1'b0;
          end else begin
            close_en           = 1'b1;
            close_tok.kind     = KIND_NUM;
            close_tok.start    = token_start;
            close_tok.len      = run_length;
            close_tok.value    = acc;
            close_tok.overflow = ovf;
            mode_next          = MODE_IDLE;
          end
        end
        MODE_NAME: begin
          if (dig || let_c) begin
            if (kw_match && (kw_prog < KwPosW'(KwLen)) && (char_q == keyword_char(kw_prog))) begin
              kw_prog_next = kw_prog + 1'b1;
            end else begin
              kw_match_next = 1'b0;
            end
            run_length_next = len_grow;
            position_next   = pos_inc;
            cont            = 1'b0;
          end else begin
            close_en        = 1'b1;
            close_tok.kind  = (kw_match && (kw_prog == KwPosW'(KwLen))) ? KIND_PRINT : KIND_ID;
            close_tok.start = token_start;
            close_tok.len   = run_length;
            mode_next       = MODE_IDLE;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase

      if (cont) begin
        if (char_q == CharNul) begin
          // End of string: report it and return every counter to the start.
          new_en           = 1'b1;
          new_tok.kind     = KIND_END;
          new_tok.start    = position;
          position_next    = '0;
          token_start_next = '0;
          run_length_next  = '0;
          acc_next         = '0;
          ovf_next         = 1'b0;
          kw_prog_next     = '0;
          kw_match_next    = 1'b0;
        end else begin
          if (char_q == CharSpace) begin
            // Spaces only separate tokens.
          end else if (dig) begin
            mode_next        = MODE_NUM;
            token_start_next = position;
            run_length_next  = LenW'(1);
            acc_next         = {{(ValW-4){1'b0}}, char_q[3:0]};
            ovf_next         = 1'b0;
          end else if (let_c) begin
            mode_next        = MODE_NAME;
            token_start_next = position;
            run_length_next  = LenW'(1);
            kw_match_next    = (char_q == keyword_char('0));
            kw_prog_next     = {{(KwPosW-1){1'b0}}, (char_q == keyword_char('0))};
          end else begin
            token_start_next = position;
            new_en           = 1'b1;
            new_tok.kind     = symbol_kind(char_q);
            new_tok.start    = position;
            new_tok.len      = LenW'(1);
            new_tok.err_char = is_symbol(char_q) ? '0 : char_q;
          end
          position_next = pos_inc;
        end
      end

      if (close_en) begin
        push.first  = close_tok;
        push.second = new_tok;
        push.count  = new_en ? 2'd2 : 2'd1;
      end else begin
        push.first  = new_tok;
        push.count  = new_en ? 2'd1 : 2'd0;
      end
      if (push.count == 2'd2) begin
        push.second.last = 1'b1;
      end else if (push.count == 2'd1) begin
        push.first.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_full   <= 1'b0;
      mode        <= MODE_IDLE;
      token_start <= '0;
      position    <= '0;
      run_length  <= '0;
      acc         <= '0;
      ovf         <= 1'b0;
      kw_prog     <= '0;
      kw_match    <= 1'b0;
    end else begin
      if (char_valid && char_ready) begin
        char_full <= 1'b1;
      end else if (advance) begin
        char_full <= 1'b0;
      end
      mode        <= mode_next;
      token_start <= token_start_next;
      position    <= position_next;
      run_length  <= run_length_next;
      acc         <= acc_next;
      ovf         <= ovf_next;
      kw_prog     <= kw_prog_next;
      kw_match    <= kw_match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      char_q <= char_code;
    end
  end

`ifndef SYNTH
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (room && char_full))
    else $error("token pushed without queue room");

  a_end_clears_position: assert property (@(posedge clk) disable iff (rst)
    (advance && (char_q == CharNul)) |=> ((position == '0) && (mode == MODE_IDLE)))
    else $error("end of string did not reset the scanner");

  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!push.first.last && push.second.last))
    else $error("wrong final-token mark on a two-token transaction");

  a_num_has_no_closer_twice: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> ((push.first.kind == KIND_NUM) || (push.first.kind == KIND_ID)
                              || (push.first.kind == KIND_PRINT)))
    else $error("two tokens without a pending token being closed");
`endif

endmodule

>>> sv/etscan_fifo.sv
// Result queue: takes up to two tokens per cycle and hands out one per transaction.
module etscan_fifo (
  input  logic                clk,
  input  logic                rst,
  input  etscan_pkg::push_t   push,
  output logic                room,
  output etscan_pkg::token_t  head,
  output logic                head_valid,
  input  logic                head_ready
);
  import etscan_pkg::*;

  token_t              mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] count;
  logic                pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && head_ready;
  assign room       = (count <= FifoCntW'(FifoDepth - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FifoPtrW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FifoCntW'(push.count) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.second;
    end
  end

endmodule

>>> verif/expression_token_scanner_top_tb.sv
// Self-checking testbench for the expression token scanner: directed table plus random strings.
`timescale 1ns / 1ps

module expression_token_scanner_top_tb;
  import etscan_pkg::*;

  localparam int        ITEM_TARGET = 1650;
  localparam int        HOLD_CYCLES = 100;
  localparam int        STALL_LIMIT = 1000;
  localparam int        MAX_REPORTS = 40;
  localparam logic [39:0] KW_TEXT   = "print";
  localparam logic [63:0] SYM_TEXT  = "+-*/();=";

  typedef enum logic [1:0] {SC_IDLE, SC_NUM, SC_NAME} scan_mode_t;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    token_t     tok;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic char_valid;
  logic char_ready;
  logic [CharW-1:0] char_code;
  logic token_valid;
  logic token_ready;
  logic [3:0] token_kind;
  logic [PosW-1:0] start_pos;
  logic [LenW-1:0] token_length;
  logic [ValW-1:0] number_value;
  logic value_overflow;
  logic [CharW-1:0] error_char;
  logic last_of_run;

  expression_token_scanner_top dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_code(char_code),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_kind(token_kind),
    .start_pos(start_pos),
    .token_length(token_length),
    .number_value(number_value),
    .value_overflow(value_overflow),
    .error_char(error_char),
    .last_of_run(last_of_run)
  );

  always #4 clk = ~clk;

  // Scanner state mirrored by the token predictor.
  scan_mode_t       mode;
  logic [PosW-1:0]  tok_start;
  logic [PosW-1:0]  pos;
  logic [ValW-1:0]  acc;
  logic             acc_ovf;
  logic [KwPosW-1:0] kw_idx;
  logic             kw_ok;
  logic [LenW-1:0]  run_len;

  token_t   scan_out[$];
  token_t   expected_tokens[$];
  dir_row_t dir_rows[$];

  bit     typed_on;
  token_t typed_tok;
  bit     idle_on;
  bit     hold_req;
  int     items;
  int     errors;
  int     stall_cycles;

  function automatic bit is_digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter_ch(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_MUL;
      "/": return KIND_DIV;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      ";": return KIND_SEMI;
      "=": return KIND_ASSIGN;
      default: return KIND_ERROR;
    endcase
  endfunction

  function automatic token_t make_token(input kind_t k, input logic [PosW-1:0] s,
                                        input logic [LenW-1:0] l, input logic [ValW-1:0] v,
                                        input logic o, input logic [7:0] e);
    token_t t;
    t.kind = k;
    t.start = s;
    t.len = l;
    t.value = v;
    t.overflow = o;
    t.err_char = e;
    t.last = 1'b0;
    return t;
  endfunction

  // Works out the tokens that one character releases and advances the scanner state.
  function automatic void scan_char(input logic [7:0] c);
    logic [34:0] prod;
    scan_out.delete();
    if (mode == SC_NUM) begin
      if (is_digit_ch(c)) begin
        prod = {4'd0, acc} * 35'd10 + {27'd0, c} - 35'h30;
        if (acc_ovf || prod > 35'h7FFF_FFFF) begin
          acc = ValMax;
          acc_ovf = 1'b1;
        end else begin
          acc = prod[ValW-1:0];
        end
        if (run_len < MaxStrLen) run_len++;
        pos++;
        return;
      end
      scan_out.insert(scan_out.size(),
                      make_token(KIND_NUM, tok_start, run_len, acc, acc_ovf, 8'h00));
      mode = SC_IDLE;
    end else if (mode == SC_NAME) begin
      if (is_letter_ch(c) || is_digit_ch(c)) begin
        if (kw_ok && kw_idx < KwLen && c == KW_TEXT[39 - 8 * kw_idx -: 8]) kw_idx++;
        else kw_ok = 1'b0;
        if (run_len < MaxStrLen) run_len++;
        pos++;
        return;
      end
      scan_out.insert(scan_out.size(),
                      make_token((kw_ok && kw_idx == KwLen) ? KIND_PRINT : KIND_ID,
                                 tok_start, run_len, '0, 1'b0, 8'h00));
      mode = SC_IDLE;
    end

    if (c == CharNul) begin
      scan_out.insert(scan_out.size(), make_token(KIND_END, pos, '0, '0, 1'b0, 8'h00));
      pos = '0;
      tok_start = '0;
      run_len = '0;
      acc = '0;
      acc_ovf = 1'b0;
      kw_idx = '0;
      kw_ok = 1'b0;
    end else begin
      if (c == CharSpace) begin
        // Spaces only separate tokens.
      end else if (is_digit_ch(c)) begin
        mode = SC_NUM;
        tok_start = pos;
        run_len = LenW'(1);
        acc = {23'd0, c - 8'h30};
        acc_ovf = 1'b0;
      end else if (is_letter_ch(c)) begin
        mode = SC_NAME;
        tok_start = pos;
        run_len = LenW'(1);
        kw_ok = (c == KW_TEXT[39 -: 8]);
        kw_idx = {2'b00, kw_ok};
      end else begin
        tok_start = pos;
        scan_out.insert(scan_out.size(),
                        make_token(punct_kind(c), pos, LenW'(1), '0, 1'b0,
                                   punct_kind(c) == KIND_ERROR ? c : 8'h00));
      end
      pos++;
    end
    if (scan_out.size() > 0) scan_out[scan_out.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
    if (want !== seen) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      errors++;
    end
  endfunction

  // Predicts on every accepted character and checks every accepted token; also the watchdog.
  always @(posedge clk) begin : monitor
    token_t want;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (char_valid && char_ready) begin
        moved = 1'b1;
        scan_char(char_code);
        if (typed_on) expected_tokens.insert(expected_tokens.size(), typed_tok);
        else foreach (scan_out[i]) expected_tokens.insert(expected_tokens.size(), scan_out[i]);
      end
      if (token_valid && token_ready) begin
        moved = 1'b1;
        if (expected_tokens.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected token, kind %0d start %0d", $time, token_kind,
                     start_pos);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          report_field("token_kind", want.kind, token_kind);
          report_field("start_pos", want.start, start_pos);
          report_field("token_length", want.len, token_length);
          report_field("number_value", want.value, number_value);
          report_field("value_overflow", want.overflow, value_overflow);
          report_field("error_char", want.err_char, error_char);
          report_field("last_of_run", want.last, last_of_run);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Token sink: random back-pressure while idle_on is set, plus one long hold-off on request.
  initial begin : sink
    int hold;
    hold = 0;
    token_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        token_ready <= 1'b0;
      end else begin
        token_ready <= !(idle_on && $urandom_range(99) < 7);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_char(input logic [7:0] c);
    while (idle_on && $urandom_range(99) < 7) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!char_ready);
    @(negedge clk);
    items++;
  endtask

  task automatic drain_tokens();
    char_valid <= 1'b0;
    do @(negedge clk); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return r < 26 ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(3) == 0 ? 8'(8'h30 + $urandom_range(9)) : rand_letter();
  endfunction

  task automatic send_fragment();
    logic [7:0] chars[$];
    logic [7:0] edges[10];
    int sel;
    int n;
    edges = '{8'h01, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80, 8'hFF};
    sel = $urandom_range(99);
    if (sel < 25) begin
      // Mostly short numbers; the long ones, of ten to fourteen digits, can overflow.
      n = $urandom_range(9) == 0 ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (n) chars.insert(chars.size(), 8'(8'h30 + $urandom_range(9)));
    end else if (sel < 50) begin
      case ($urandom_range(4))
        0: n = 5;
        1: n = $urandom_range(1, 4);
        2: n = 5 + $urandom_range(1, 2);
        default: n = 0;
      endcase
      for (int i = 0; i < n; i++)
        chars.insert(chars.size(), i < 5 ? KW_TEXT[39 - 8 * i -: 8] : rand_alnum());
      if (n == 0) begin
        chars.insert(chars.size(), rand_letter());
        repeat ($urandom_range(5)) chars.insert(chars.size(), rand_alnum());
      end
    end else if (sel < 65) begin
      chars.insert(chars.size(), SYM_TEXT[8 * $urandom_range(7) +: 8]);
    end else if (sel < 78) begin
      chars.insert(chars.size(), CharSpace);
    end else if (sel < 95) begin
      chars.insert(chars.size(),
                   $urandom_range(1) ? 8'($urandom_range(255)) : edges[$urandom_range(9)]);
    end else begin
      chars.insert(chars.size(), CharNul);
    end
    foreach (chars[i]) send_char(chars[i]);
  endtask

  function automatic void add_plain(input logic [7:0] c);
    dir_row_t r;
    r.ch = c;
    r.typed = 1'b0;
    r.tok = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Rows whose single token is obvious; last_of_run is always set on those.
  function automatic void add_typed(input logic [7:0] c, input kind_t k,
                                    input logic [PosW-1:0] s, input logic [LenW-1:0] l,
                                    input logic [7:0] e);
    dir_row_t r;
    r.ch = c;
    r.typed = 1'b1;
    r.tok = make_token(k, s, l, '0, 1'b0, e);
    r.tok.last = 1'b1;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin : stimulus
    bit held;
    bit paused;
    rst = 1'b1;
    char_valid = 1'b0;
    char_code = '0;
    hold_req = 1'b0;
    idle_on = 1'b1;
    typed_on = 1'b0;
    typed_tok = '0;
    items = 0;
    errors = 0;
    stall_cycles = 0;
    held = 1'b0;
    paused = 1'b0;
    mode = SC_IDLE;
    tok_start = '0;
    pos = '0;
    acc = '0;
    acc_ovf = 1'b0;
    kw_idx = '0;
    kw_ok = 1'b0;
    run_len = '0;

    add_typed("+", KIND_PLUS, PosW'(0), LenW'(1), 8'h00);
    add_typed(8'hFF, KIND_ERROR, PosW'(1), LenW'(1), 8'hFF);
    add_typed(CharNul, KIND_END, PosW'(2), LenW'(0), 8'h00);
    add_typed("-", KIND_MINUS, PosW'(0), LenW'(1), 8'h00);
    add_plain("*");
    add_plain("/");
    add_plain("(");
    add_plain(")");
    add_plain(";");
    add_typed("=", KIND_ASSIGN, PosW'(6), LenW'(1), 8'h00);
    add_plain("p");
    add_plain("r");
    add_plain("i");
    add_plain("n");
    add_plain("t");
    add_plain(CharSpace);
    add_plain("9");
    add_plain("9");
    add_plain("x");   // a letter closes the number
    add_plain("7");   // a digit extends the name
    add_plain(8'h80); // closes the name, then an error for a byte above 127
    add_plain("5");
    add_plain(CharNul);
    add_typed(8'h01, KIND_ERROR, PosW'(0), LenW'(1), 8'h01);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_on = dir_rows[i].typed;
      typed_tok = dir_rows[i].tok;
      send_char(dir_rows[i].ch);
    end
    typed_on = 1'b0;
    drain_tokens();

    while (items < ITEM_TARGET) begin
      idle_on = !(items >= 600 && items < 900);
      if (!held && items >= 1100) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && items >= 1350) begin
        drain_tokens();
        paused = 1'b1;
      end
      send_fragment();
    end

    char_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> expression_token_scanner_top.f
sv/etscan_pkg.sv
sv/etscan_core.sv
sv/etscan_fifo.sv
sv/expression_token_scanner_top.sv
verif/expression_token_scanner_top_tb.sv
